// ===== hdl/ckhs_pkg.sv =====
// ----------------------------------------------------------------------------
// ckhs_pkg
// shared types, widths, defaults and the base decoder of the k-mer sampler
// ----------------------------------------------------------------------------
package ckhs_pkg;

    // parameter defaults
    localparam int MAX_KMER_LEN_DEF       = 31;
    localparam int MAX_PARTITION_BITS_DEF = 16;

    // register and field widths
    localparam int KLEN_W     = 5;
    localparam int WSTEP_W    = 11;
    localparam int PBITS_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int RUN_W      = 5;
    localparam int PHASE_W    = 10;
    localparam int PART_W     = 16;
    localparam int KEY_W      = 62;

    localparam logic [RUN_W-1:0]   RUN_MAX    = 5'd31;
    localparam logic [WSTEP_W-1:0] WINDOW_MAX = 11'd1024;

    // register reset values
    localparam logic [KLEN_W-1:0]  KLEN_RST  = 5'd31;
    localparam logic [WSTEP_W-1:0] WSTEP_RST = 11'd1;
    localparam logic [PBITS_W-1:0] PBITS_RST = 5'd12;

    // queue depths
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KMER_LENGTH    = 2'd0,
        CFG_WINDOW_STEP    = 2'd1,
        CFG_PARTITION_BITS = 2'd2
    } t_cfg_idx;

    // clamped configuration as seen by front and back
    typedef struct packed {
        logic [KLEN_W-1:0]  kmer_len;
        logic [WSTEP_W-1:0] win_step;
        logic [PBITS_W-1:0] part_bits;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } t_base;

    // back end status for checking
    typedef struct packed {
        logic out_push;
        logic out_full;
    } t_back_stat;

    function automatic t_base decode_base(input logic [7:0] ch);
        t_base b;
        b.valid = 1'b1;
        b.code  = 2'd0;
        case (ch)
            8'd0, 8'd1, 8'd2, 8'd3: b.code = ch[1:0];
            "A", "a":               b.code = 2'd0;
            "C", "c":               b.code = 2'd1;
            "G", "g":               b.code = 2'd2;
            "T", "t", "U", "u":     b.code = 2'd3;
            default:                b.valid = 1'b0;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/canonical_kmer_hash_sampler_top.sv =====
// ----------------------------------------------------------------------------
// canonical_kmer_hash_sampler_top
// canonical k-mer extraction with masked invertible 2k-bit hash and partition
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                   payload
// --------  ---------  --------------------------  ---------------------------------
// input     in         i_push / o_full             i_base_char, i_sequence_start
// result    out        o_empty / i_pop             o_partition_index, o_bucket_key
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// one base per cycle while o_full is low; the strand shift registers update in the cycle
// a request is accepted, so the front takes a base every cycle that the middle queue has room
// a sampled k-mer reaches the result ports through the middle queue, four hash stages,
// then the result queue
// reset is synchronous: strand state, run, phase and both queues clear,
// registers return to k=31, w=1, p=12
// o_full rises when the 4-entry middle queue is full; the hash pipeline issues
// only while results queued plus in flight stay below 8, so a stalled consumer
// backs up into the middle queue and then the input
//
module canonical_kmer_hash_sampler_top #(
    parameter int MAX_KMER_LEN       = ckhs_pkg::MAX_KMER_LEN_DEF,
    parameter int MAX_PARTITION_BITS = ckhs_pkg::MAX_PARTITION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input queue side
    input  logic                             i_push,
    output logic                             o_full,
    input  logic [7:0]                       i_base_char,
    input  logic                             i_sequence_start,
    // result queue side
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [ckhs_pkg::PART_W-1:0]      o_partition_index,
    output logic [ckhs_pkg::KEY_W-1:0]       o_bucket_key,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ckhs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ckhs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int KW = 2 * MAX_KMER_LEN;

    // configuration registers, raw as written
    logic [ckhs_pkg::KLEN_W-1:0]  r_kmer_length;
    logic [ckhs_pkg::WSTEP_W-1:0] r_window_step;
    logic [ckhs_pkg::PBITS_W-1:0] r_partition_bits;

    ckhs_pkg::t_cfg       cfg;
    ckhs_pkg::t_back_stat w_back_stat;
    ckhs_pkg::t_base      w_in_base;

    logic          w_accept;
    logic          w_mid_push;
    logic [KW-1:0] w_canon;
    logic          w_mid_full;
    logic          w_mid_empty;
    logic          w_mid_pop;
    logic [KW-1:0] w_mid_data;
    logic [$clog2(ckhs_pkg::MID_DEPTH):0] w_mid_count;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length    <= ckhs_pkg::KLEN_RST;
            r_window_step    <= ckhs_pkg::WSTEP_RST;
            r_partition_bits <= ckhs_pkg::PBITS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ckhs_pkg::CFG_KMER_LENGTH:
                    r_kmer_length <= i_cfg_data[ckhs_pkg::KLEN_W-1:0];
                ckhs_pkg::CFG_WINDOW_STEP:
                    r_window_step <= i_cfg_data[ckhs_pkg::WSTEP_W-1:0];
                ckhs_pkg::CFG_PARTITION_BITS:
                    r_partition_bits <= i_cfg_data[ckhs_pkg::PBITS_W-1:0];
                default: ;
            endcase
        end
    end

    // out-of-range settings clamp: zero acts as one, large values saturate
    always_comb begin
        cfg.kmer_len = r_kmer_length;
        if (r_kmer_length == '0)
            cfg.kmer_len = ckhs_pkg::KLEN_W'(1);
        else if (r_kmer_length > ckhs_pkg::KLEN_W'(MAX_KMER_LEN))
            cfg.kmer_len = ckhs_pkg::KLEN_W'(MAX_KMER_LEN);

        cfg.win_step = r_window_step;
        if (r_window_step == '0)
            cfg.win_step = ckhs_pkg::WSTEP_W'(1);
        else if (r_window_step > ckhs_pkg::WINDOW_MAX)
            cfg.win_step = ckhs_pkg::WINDOW_MAX;

        cfg.part_bits = r_partition_bits;
        if (r_partition_bits == '0)
            cfg.part_bits = ckhs_pkg::PBITS_W'(1);
        else if (r_partition_bits > ckhs_pkg::PBITS_W'(MAX_PARTITION_BITS))
            cfg.part_bits = ckhs_pkg::PBITS_W'(MAX_PARTITION_BITS);
    end

    assign o_full    = w_mid_full;
    assign w_accept  = i_push && !w_mid_full;
    assign w_in_base = ckhs_pkg::decode_base(i_base_char);

    // front: shift registers and sampling decision
    ckhs_front #(
        .MAX_KMER_LEN (MAX_KMER_LEN)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_accept         (w_accept),
        .i_base_char      (i_base_char),
        .i_sequence_start (i_sequence_start),
        .o_emit           (w_mid_push),
        .o_canon          (w_canon)
    );

    // middle queue of canonical k-mers waiting for the hash
    ckhs_fifo #(
        .W     (KW),
        .DEPTH (ckhs_pkg::MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_canon),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_empty (w_mid_empty),
        .o_data  (w_mid_data),
        .o_count (w_mid_count)
    );

    // back: hash pipeline and result queue
    ckhs_back #(
        .MAX_KMER_LEN (MAX_KMER_LEN)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_mid_empty       (w_mid_empty),
        .i_mid_data        (w_mid_data),
        .o_mid_pop         (w_mid_pop),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_partition_index (o_partition_index),
        .o_bucket_key      (o_bucket_key),
        .o_stat            (w_back_stat)
    );

    // both queues come out of reset empty: the result queue empty, the middle queue not full
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");

    // a non-nucleotide character never produces a k-mer
    a_invalid_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_in_base.valid) |-> !w_mid_push)
        else $error("k-mer queued for an invalid character");

    // issue credit keeps the result queue from overflowing
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_stat.out_push |-> !w_back_stat.out_full)
        else $error("hash result pushed into a full result queue");

    // middle queue count equals its depth whenever it reports full
    a_mid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_full |-> (w_mid_count == ($clog2(ckhs_pkg::MID_DEPTH)+1)'(ckhs_pkg::MID_DEPTH)))
        else $error("middle queue count inconsistent with full");

endmodule

// ===== hdl/ckhs_fifo.sv =====
// ----------------------------------------------------------------------------
// ckhs_fifo
// small register queue with push/full and pop/empty, head shown while not empty
// ----------------------------------------------------------------------------
module ckhs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [W-1:0]               i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [W-1:0]               o_data,
    output logic [$clog2(DEPTH):0]     o_count
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0] r_mem [DEPTH];
    logic [AW:0]  r_wp;
    logic [AW:0]  r_rp;
    logic         wr_en;
    logic         rd_en;

    assign o_count = r_wp - r_rp;
    assign o_full  = (o_count == (AW+1)'(DEPTH));
    assign o_empty = (r_wp == r_rp);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (wr_en) r_wp <= r_wp + 1'b1;
            if (rd_en) r_rp <= r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp[AW-1:0]] <= i_data;
        end
    end

endmodule

// ===== hdl/ckhs_front.sv =====
// ----------------------------------------------------------------------------
// ckhs_front
// base decode, strand shift registers, run length and window phase
// ----------------------------------------------------------------------------
module ckhs_front #(
    parameter int MAX_KMER_LEN = ckhs_pkg::MAX_KMER_LEN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ckhs_pkg::t_cfg            i_cfg,
    input  logic                      i_accept,
    input  logic [7:0]                i_base_char,
    input  logic                      i_sequence_start,
    output logic                      o_emit,
    output logic [2*MAX_KMER_LEN-1:0] o_canon
);
    localparam int KW = 2 * MAX_KMER_LEN;

    logic [KW-1:0]                    r_fwd, n_fwd;
    logic [KW-1:0]                    r_rev, n_rev;
    logic [ckhs_pkg::RUN_W-1:0]       r_run, n_run;
    logic [ckhs_pkg::PHASE_W-1:0]     r_phase, n_phase;

    logic [KW-1:0]                    mask;
    logic [KW-1:0]                    fwd0, rev0;
    logic [ckhs_pkg::RUN_W-1:0]       run0;
    logic [ckhs_pkg::PHASE_W-1:0]     phase0;
    logic [ckhs_pkg::WSTEP_W-1:0]     phase_inc;
    logic [ckhs_pkg::KLEN_W-1:0]      k_m1;
    ckhs_pkg::t_base                  base;
    logic                             emit;

    assign mask = {KW{1'b1}} >> (7'(KW) - {1'b0, i_cfg.kmer_len, 1'b0});
    assign k_m1 = i_cfg.kmer_len - 1'b1;
    assign base = ckhs_pkg::decode_base(i_base_char);

    // sequence start clears the run before the character is taken
    assign fwd0   = i_sequence_start ? '0 : r_fwd;
    assign rev0   = i_sequence_start ? '0 : r_rev;
    assign run0   = i_sequence_start ? '0 : r_run;
    assign phase0 = i_sequence_start ? '0 : r_phase;
    assign phase_inc = {1'b0, phase0} + 1'b1;

    always_comb begin
        n_fwd   = r_fwd;
        n_rev   = r_rev;
        n_run   = r_run;
        n_phase = r_phase;
        emit    = 1'b0;
        if (i_accept) begin
            if (!base.valid) begin
                n_fwd   = '0;
                n_rev   = '0;
                n_run   = '0;
                n_phase = '0;
            end else begin
                n_fwd = ((fwd0 << 2) | KW'(base.code)) & mask;
                n_rev = ((rev0 >> 2) | (KW'(2'd3 - base.code) << {k_m1, 1'b0})) & mask;
                n_run = (run0 < ckhs_pkg::RUN_MAX) ? run0 + 1'b1 : run0;
                n_phase = phase0;
                if (n_run >= i_cfg.kmer_len) begin
                    emit    = (phase0 == '0);
                    n_phase = (phase_inc >= i_cfg.win_step) ? '0
                                                            : phase_inc[ckhs_pkg::PHASE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd   <= '0;
            r_rev   <= '0;
            r_run   <= '0;
            r_phase <= '0;
        end else begin
            r_fwd   <= n_fwd;
            r_rev   <= n_rev;
            r_run   <= n_run;
            r_phase <= n_phase;
        end
    end

    // canonical strand is the smaller one
    assign o_canon = (n_fwd < n_rev) ? n_fwd : n_rev;
    assign o_emit  = emit;

endmodule

// ===== hdl/ckhs_back.sv =====
// ----------------------------------------------------------------------------
// ckhs_back
// four-stage masked integer hash, partition split and result queue
// ----------------------------------------------------------------------------
module ckhs_back #(
    parameter int MAX_KMER_LEN = ckhs_pkg::MAX_KMER_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ckhs_pkg::t_cfg               i_cfg,
    input  logic                         i_mid_empty,
    input  logic [2*MAX_KMER_LEN-1:0]    i_mid_data,
    output logic                         o_mid_pop,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic [ckhs_pkg::PART_W-1:0]  o_partition_index,
    output logic [ckhs_pkg::KEY_W-1:0]   o_bucket_key,
    output ckhs_pkg::t_back_stat         o_stat
);
    localparam int KW     = 2 * MAX_KMER_LEN;
    localparam int XW     = (KW > ckhs_pkg::PART_W) ? KW : ckhs_pkg::PART_W;
    localparam int NSTG   = 4;
    localparam int OCW    = $clog2(ckhs_pkg::OUT_DEPTH) + 1;
    localparam int OW     = ckhs_pkg::PART_W + ckhs_pkg::KEY_W;

    function automatic logic [KW-1:0] stg1(input logic [KW-1:0] v, input logic [KW-1:0] m);
        logic [KW-1:0] a;
        a = (~v + (v << 21)) & m;
        return a ^ (a >> 24);
    endfunction

    function automatic logic [KW-1:0] stg2(input logic [KW-1:0] v, input logic [KW-1:0] m);
        logic [KW-1:0] a;
        a = (v + (v << 3) + (v << 8)) & m;
        return a ^ (a >> 14);
    endfunction

    function automatic logic [KW-1:0] stg3(input logic [KW-1:0] v, input logic [KW-1:0] m);
        logic [KW-1:0] a;
        a = (v + (v << 2) + (v << 4)) & m;
        return a ^ (a >> 28);
    endfunction

    function automatic logic [KW-1:0] stg4(input logic [KW-1:0] v, input logic [KW-1:0] m);
        return (v + (v << 31)) & m;
    endfunction

    logic [NSTG-1:0]             r_v;
    logic [KW-1:0]               r_d [NSTG];
    logic [KW-1:0]               mask;
    logic [OCW-1:0]              out_count;
    logic                        out_full;
    logic                        issue;
    logic [XW-1:0]               hash_x;
    logic [ckhs_pkg::PART_W-1:0] pmask;
    logic [ckhs_pkg::PART_W-1:0] part;
    logic [ckhs_pkg::KEY_W-1:0]  key;
    logic [OW-1:0]               out_data;

    assign mask = {KW{1'b1}} >> (7'(KW) - {1'b0, i_cfg.kmer_len, 1'b0});

    // issue only while the result queue has room for everything in flight
    assign issue = !i_mid_empty &&
                   ((OCW+1)'(out_count) + (OCW+1)'($countones(r_v))
                    < (OCW+1)'(ckhs_pkg::OUT_DEPTH));
    assign o_mid_pop = issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NSTG-2:0], issue};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d[0] <= stg1(i_mid_data, mask);
        r_d[1] <= stg2(r_d[0], mask);
        r_d[2] <= stg3(r_d[1], mask);
        r_d[3] <= stg4(r_d[2], mask);
    end

    // low p bits select the partition, the rest form the key
    assign hash_x = XW'(r_d[NSTG-1]);
    assign pmask  = ckhs_pkg::PART_W'((17'd1 << i_cfg.part_bits) - 17'd1);
    assign part   = hash_x[ckhs_pkg::PART_W-1:0] & pmask;
    assign key    = ckhs_pkg::KEY_W'(r_d[NSTG-1] >> i_cfg.part_bits);
    assign out_data = {part, key};

    logic [OW-1:0] head;

    ckhs_fifo #(
        .W     (OW),
        .DEPTH (ckhs_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v[NSTG-1]),
        .i_data  (out_data),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (head),
        .o_count (out_count)
    );

    assign o_partition_index = head[OW-1:ckhs_pkg::KEY_W];
    assign o_bucket_key      = head[ckhs_pkg::KEY_W-1:0];

    assign o_stat.out_push = r_v[NSTG-1];
    assign o_stat.out_full = out_full;

endmodule
